// ===== design/tseh_pkg.sv =====
// shared constants, codes and types of the strip energy histogram
package tseh_pkg;

  localparam int SIDES      = 4;
  localparam int STRIPS     = 32;
  localparam int BINS       = 4096;
  localparam int COUNT_BITS = 32;

  localparam int CELLS  = SIDES * STRIPS * BINS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [11:0] THRESHOLD_RESET = 12'd100;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  typedef enum logic [1:0] {
    OP_RECORD     = 2'd0,
    OP_READ_BIN   = 2'd1,
    OP_READ_EVENT = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_COUNTED = 2'd0,
    ST_BELOW   = 2'd1,
    ST_DROPPED = 2'd2,
    ST_DATA    = 2'd3
  } status_t;

  typedef struct packed {
    logic  below_thr;
    logic  in_range;
    addr_t addr;
  } hit_class_t;

endpackage

// ===== design/tseh_channels.sv =====
// valid/ready channel interfaces for requests, results and the threshold register
interface tseh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  side_select;
  logic [5:0]  strip_number;
  logic [15:0] energy_value;
  logic        last_hit_of_event;

  modport source (output valid, opcode, side_select, strip_number, energy_value,
                  last_hit_of_event, input ready);
  modport sink   (input valid, opcode, side_select, strip_number, energy_value,
                  last_hit_of_event, output ready);
endinterface

interface tseh_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status_code;
  logic [31:0] count_value;

  modport source (output valid, status_code, count_value, input ready);
  modport sink   (input valid, status_code, count_value, output ready);
endinterface

interface tseh_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] energy_threshold;

  modport source (output valid, energy_threshold, input ready);
  modport sink   (input valid, energy_threshold, output ready);
endinterface

// ===== design/tseh_ram.sv =====
// generic single-write, single-read ram with registered read data
module tseh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tseh_decode.sv =====
// threshold test, range check and bin address of a request
module tseh_decode (
  input  logic [1:0]           side_select,
  input  logic [5:0]           strip_number,
  input  logic [15:0]          energy_value,
  input  logic [11:0]          energy_threshold,
  output tseh_pkg::hit_class_t cls
);
  import tseh_pkg::*;

  logic [31:0] flat_index;

  always_comb begin
    flat_index = ((32'(side_select) * 32'(STRIPS)) + 32'(strip_number) - 32'd1) * 32'(BINS)
                 + 32'(energy_value);
    cls.below_thr = energy_value <= 16'(energy_threshold);
    cls.in_range  = (32'(side_select) < 32'(SIDES)) && (strip_number != 6'd0) &&
                    (32'(strip_number) <= 32'(STRIPS)) &&
                    (32'(energy_value) < 32'(BINS));
    cls.addr      = flat_index[ADDR_W-1:0];
  end

endmodule

// ===== design/thresholded_strip_energy_histogram_core.sv =====
// Multichannel-analyzer histogram for strip detectors: one saturating counter per side, strip
// and energy bin kept in a single ram, plus an event counter. After reset the block sweeps the
// bin ram to zero, one entry per cycle, over all SIDES*STRIPS*BINS entries (524288 with the
// package values); requests are held off during the sweep while threshold writes are taken at
// any time. For each request the accept cycle issues the ram read; the read-modify-write state
// then does the saturating increment, writes the bin back for a counted record and loads the
// result register. A result not yet taken holds the block in the read-modify-write state.
module thresholded_strip_energy_histogram_core (
  input logic clk,
  input logic rst,
  tseh_req_if.sink   req,
  tseh_rsp_if.source rsp,
  tseh_cfg_if.sink   cfg
);
  import tseh_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW
  } state_t;

  state_t      state;
  addr_t       clear_addr;
  logic [11:0] threshold;
  logic [31:0] event_count;
  logic [1:0]  op_q;
  hit_class_t  cls_q;
  hit_class_t  cls;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_count;
  logic [1:0]  out_status_next;
  logic [31:0] out_count_next;

  logic   accept;
  logic   out_free;
  logic   ram_we;
  addr_t  ram_waddr;
  count_t ram_wdata;
  count_t rdata;
  count_t bumped;

  tseh_decode u_decode (
    .side_select      (req.side_select),
    .strip_number     (req.strip_number),
    .energy_value     (req.energy_value),
    .energy_threshold (threshold),
    .cls              (cls)
  );

  tseh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CELLS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (cls.addr),
    .rdata (rdata)
  );

  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid && req.ready;
  assign cfg.ready       = 1'b1;
  assign rsp.valid       = out_valid;
  assign rsp.status_code = out_status;
  assign rsp.count_value = out_count;
  assign out_free        = !out_valid || rsp.ready;

  // counter holds at all ones
  assign bumped = (rdata == '1) ? rdata : rdata + count_t'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clear_addr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_RMW && out_free && op_q == OP_RECORD &&
                 !cls_q.below_thr && cls_q.in_range) begin
      ram_we    = 1'b1;
      ram_waddr = cls_q.addr;
      ram_wdata = bumped;
    end
  end

  always_comb begin
    out_status_next = ST_DROPPED;
    out_count_next  = '0;
    case (op_q)
      OP_RECORD: begin
        if (cls_q.below_thr) begin
          out_status_next = ST_BELOW;
        end else if (cls_q.in_range) begin
          out_status_next = ST_COUNTED;
          out_count_next  = 32'(bumped);
        end
      end
      OP_READ_BIN: begin
        if (cls_q.in_range) begin
          out_status_next = ST_DATA;
          out_count_next  = 32'(rdata);
        end
      end
      OP_READ_EVENT: begin
        out_status_next = ST_DATA;
        out_count_next  = event_count;
      end
      default: begin
        out_status_next = ST_DROPPED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clear_addr  <= '0;
      threshold   <= THRESHOLD_RESET;
      event_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        threshold <= cfg.energy_threshold;
      end
      if (state == S_RMW && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + addr_t'(1);
          if (clear_addr == addr_t'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q  <= req.opcode;
            cls_q <= cls;
            if (req.opcode == OP_RECORD && req.last_hit_of_event) begin
              event_count <= event_count + 32'd1;
            end
            state <= S_RMW;
          end
        end
        S_RMW: begin
          if (out_free) begin
            out_status <= out_status_next;
            out_count  <= out_count_next;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a transfer in always moves the sequencer into the read-modify-write state
  a_accept_to_rmw: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RMW) && !req.ready)
    else $error("accepted request did not enter read-modify-write");

  a_event_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && req.opcode == OP_RECORD && req.last_hit_of_event) |=>
      (event_count == $past(event_count) + 32'd1))
    else $error("event counter did not advance on end-of-event hit");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_RMW))
    else $error("result appeared outside read-modify-write");

  a_write_only_counted: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != S_CLEAR) |->
      (op_q == OP_RECORD && cls_q.in_range && !cls_q.below_thr))
    else $error("bin write for a request that is not counted");

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the thresholded strip energy histogram core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tseh_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT  = 2_500_000;
  localparam int         PHASE_ITEMS  = 240;
  localparam int         HOT_CELLS    = 8;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  side;
    logic [5:0]  strip;
    logic [15:0] energy;
    logic        last;
  } hit_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] count;
  } hist_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tseh_req_if req_ch();
  tseh_rsp_if rsp_ch();
  tseh_cfg_if cfg_ch();

  thresholded_strip_energy_histogram_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // histogram state as the block should hold it
  count_t      bin_tally [int];
  logic [31:0] events_closed = '0;
  logic [11:0] threshold_now = THRESHOLD_RESET;

  hit_req_t  pending_hits [$];
  hist_rsp_t results_due [$];

  int errors        = 0;
  int hits_sent     = 0;
  int results_seen  = 0;
  int settings_used = 0;
  int status_tally [4] = '{0, 0, 0, 0};

  int       src_wait = 0;
  int       src_calm = 0;
  int       snk_wait = 0;
  int       snk_calm = 0;
  int       snk_gap;
  hit_req_t next_hit;
  hist_rsp_t want;

  int unsigned cycle_count = 0;

  // applies one request to the histogram state and returns the result it gives
  function automatic hist_rsp_t histogram_update(hit_req_t h);
    hist_rsp_t r;
    bit        in_range;
    int        bin_idx;
    r.status = ST_DROPPED;
    r.count  = '0;
    in_range = (h.side < SIDES) && (h.strip != 0) && (h.strip <= STRIPS) && (h.energy < BINS);
    bin_idx = (int'(h.side) * STRIPS + int'(h.strip) - 1) * BINS + int'(h.energy);
    case (h.op)
      OP_RECORD: begin
        // threshold is tested before the range check
        if (h.energy <= threshold_now) begin
          r.status = ST_BELOW;
        end else if (in_range) begin
          if (!bin_tally.exists(bin_idx)) bin_tally[bin_idx] = '0;
          if (bin_tally[bin_idx] != {COUNT_BITS{1'b1}})
            bin_tally[bin_idx] = bin_tally[bin_idx] + 1'b1;
          r.status = ST_COUNTED;
          r.count  = bin_tally[bin_idx];
        end
        if (h.last) events_closed = events_closed + 1'b1;
      end
      OP_READ_BIN: begin
        if (in_range) begin
          r.status = ST_DATA;
          r.count  = bin_tally.exists(bin_idx) ? bin_tally[bin_idx] : '0;
        end
      end
      OP_READ_EVENT: begin
        r.status = ST_DATA;
        r.count  = events_closed;
      end
      default: ;
    endcase
    return r;
  endfunction

  // idle length for one item, with occasional runs of back-to-back transfers
  function automatic int pause_length(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  task automatic queue_hit(logic [1:0] op, logic [1:0] side, logic [5:0] strip,
                           logic [15:0] energy, logic last);
    pending_hits.push_back(hit_req_t'{op, side, strip, energy, last});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_hits.size() != 0 || req_ch.valid || results_due.size() != 0);
  endtask

  task automatic write_threshold(logic [11:0] value);
    @(posedge clk);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.energy_threshold <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid  <= 1'b0;
    threshold_now = value;
    settings_used++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      src_wait     <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        results_due.push_back(histogram_update(hit_req_t'{req_ch.opcode, req_ch.side_select,
            req_ch.strip_number, req_ch.energy_value, req_ch.last_hit_of_event}));
        hits_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (src_wait > 0) begin
          src_wait     <= src_wait - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_hits.size() > 0) begin
          next_hit = pending_hits.pop_front();
          req_ch.opcode            <= next_hit.op;
          req_ch.side_select       <= next_hit.side;
          req_ch.strip_number      <= next_hit.strip;
          req_ch.energy_value      <= next_hit.energy;
          req_ch.last_hit_of_event <= next_hit.last;
          req_ch.valid             <= 1'b1;
          src_wait                 <= pause_length(src_calm);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      snk_wait     <= 0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, status %0d count %0d",
                 $time, rsp_ch.status_code, rsp_ch.count_value);
      end else begin
        want = results_due.pop_front();
        if (rsp_ch.status_code !== want.status) begin
          errors++;
          $display("%0t: status_code mismatch, expected %0d, actual %0d",
                   $time, want.status, rsp_ch.status_code);
        end
        if (rsp_ch.count_value !== want.count) begin
          errors++;
          $display("%0t: count_value mismatch, expected %0d, actual %0d",
                   $time, want.count, rsp_ch.count_value);
        end
        if (!$isunknown(rsp_ch.status_code)) status_tally[rsp_ch.status_code]++;
      end
      snk_gap = pause_length(snk_calm);
      snk_wait     <= snk_gap;
      rsp_ch.ready <= (snk_gap == 0);
    end else if (snk_wait > 0) begin
      snk_wait     <= snk_wait - 1;
      rsp_ch.ready <= (snk_wait == 1);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [11:0] thr_list [6];
    hit_req_t    hot [HOT_CELLS];
    hit_req_t    h;
    int          pick;
    int          zone;

    req_ch.valid             = 1'b0;
    req_ch.opcode            = '0;
    req_ch.side_select       = '0;
    req_ch.strip_number      = '0;
    req_ch.energy_value      = '0;
    req_ch.last_hit_of_event = 1'b0;
    rsp_ch.ready             = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.energy_threshold  = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at the reset threshold of 100
    queue_hit(OP_READ_EVENT, 2'd0, 6'd0,  16'd0,     1'b0);
    queue_hit(OP_READ_BIN,   2'd0, 6'd1,  16'd0,     1'b0);
    queue_hit(OP_RECORD,     2'd0, 6'd1,  16'd100,   1'b0);  // equal to threshold
    queue_hit(OP_RECORD,     2'd0, 6'd1,  16'd0,     1'b0);
    queue_hit(OP_RECORD,     2'd0, 6'd1,  16'd101,   1'b0);
    queue_hit(OP_RECORD,     2'd0, 6'd1,  16'd101,   1'b1);
    queue_hit(OP_RECORD,     2'd3, 6'd32, 16'd101,   1'b0);
    queue_hit(OP_RECORD,     2'd3, 6'd32, 16'd4095,  1'b0);
    queue_hit(OP_RECORD,     2'd3, 6'd32, 16'd4095,  1'b1);
    queue_hit(OP_RECORD,     2'd0, 6'd1,  16'd4096,  1'b0);
    queue_hit(OP_RECORD,     2'd2, 6'd1,  16'd65535, 1'b1);
    queue_hit(OP_RECORD,     2'd1, 6'd0,  16'd200,   1'b0);
    queue_hit(OP_RECORD,     2'd1, 6'd33, 16'd200,   1'b0);
    queue_hit(OP_RECORD,     2'd2, 6'd63, 16'd200,   1'b1);
    queue_hit(OP_RECORD,     2'd1, 6'd0,  16'd50,    1'b1);  // below wins over bad strip
    queue_hit(OP_UNUSED,     2'd0, 6'd1,  16'd101,   1'b1);
    queue_hit(OP_READ_BIN,   2'd0, 6'd1,  16'd101,   1'b1);
    queue_hit(OP_READ_BIN,   2'd3, 6'd32, 16'd4095,  1'b0);
    queue_hit(OP_READ_BIN,   2'd0, 6'd0,  16'd101,   1'b0);
    queue_hit(OP_READ_BIN,   2'd0, 6'd33, 16'd101,   1'b0);
    queue_hit(OP_READ_BIN,   2'd0, 6'd1,  16'd4096,  1'b0);
    queue_hit(OP_READ_BIN,   2'd2, 6'd16, 16'd2048,  1'b0);
    queue_hit(OP_RECORD,     2'd1, 6'd16, 16'd2048,  1'b0);
    queue_hit(OP_READ_EVENT, 2'd3, 6'd63, 16'd65535, 1'b1);
    wait_drained();

    thr_list = '{12'd0, 12'd4095, 12'd1, 12'($urandom_range(0, 4095)), 12'd4094,
                 12'($urandom_range(0, 400))};

    foreach (thr_list[p]) begin
      write_threshold(thr_list[p]);
      @(negedge clk);
      // a few busy cells per setting so that counts build up and reads hit them
      foreach (hot[k]) begin
        hot[k].side  = 2'($urandom_range(0, 3));
        hot[k].strip = (k == 0) ? 6'd1 : (k == 1) ? 6'd32 : 6'($urandom_range(1, 32));
        if (threshold_now < 12'd4095 && $urandom_range(0, 3) != 0)
          hot[k].energy = (k == 2) ? 16'(threshold_now + 1)
                                   : 16'($urandom_range(threshold_now + 1, BINS - 1));
        else
          hot[k].energy = 16'($urandom_range(0, BINS - 1));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick   = $urandom_range(0, 99);
        h.last = ($urandom_range(0, 3) == 0);
        if (pick < 5) begin
          h.op     = 2'($urandom_range(0, 3));
          h.side   = 2'($urandom_range(0, 3));
          h.strip  = 6'($urandom_range(0, 63));
          h.energy = 16'($urandom_range(0, 65535));
        end else begin
          zone   = $urandom_range(0, 99);
          h.side = 2'($urandom_range(0, 3));
          if (zone < 60) begin
            h = hot[$urandom_range(0, HOT_CELLS - 1)];
            h.last = ($urandom_range(0, 3) == 0);
          end else if (zone < 72) begin
            h.strip  = 6'($urandom_range(1, 32));
            h.energy = 16'(threshold_now + $urandom_range(0, 1));
          end else if (zone < 88) begin
            h.strip  = 6'($urandom_range(1, 32));
            h.energy = 16'($urandom_range(0, BINS - 1));
          end else if ($urandom_range(0, 1) == 0) begin
            h.strip  = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
            h.energy = 16'($urandom_range(0, 65535));
          end else begin
            h.strip  = 6'($urandom_range(1, 32));
            h.energy = 16'($urandom_range(BINS, 65535));
          end
          if (pick < 55)      h.op = OP_RECORD;
          else if (pick < 85) h.op = OP_READ_BIN;
          else if (pick < 95) h.op = OP_READ_EVENT;
          else                h.op = OP_UNUSED;
        end
        pending_hits.push_back(h);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("tb: %0d requests under %0d threshold writes, %0d results checked",
             hits_sent, settings_used, results_seen);
    $display("tb: counted %0d, below threshold %0d, dropped %0d, read data %0d, events %0d",
             status_tally[ST_COUNTED], status_tally[ST_BELOW], status_tally[ST_DROPPED],
             status_tally[ST_DATA], events_closed);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
